// ===== src/chm_pkg.sv =====
// chm_pkg: shared types and constants for the chained hash map engine
// no dependencies
package chm_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int CNT_W = 11;

  typedef enum logic [1:0] {
    KIND_SET = 2'd0,
    KIND_GET = 2'd1,
    KIND_DEL = 2'd2,
    KIND_BAD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

endpackage

// ===== src/chm_req_if.sv =====
// chm_req_if: request channel (kind, key, value) with valid/ready
// depends on chm_pkg
interface chm_req_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   value;
  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

// ===== src/chm_rsp_if.sv =====
// chm_rsp_if: response channel (status, read_value, stored_count)
// depends on chm_pkg
interface chm_rsp_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [VAL_W-1:0]   read_value;
  logic [CNT_W-1:0]   stored_count;
  modport source (output valid, status, read_value, stored_count, input ready);
  modport sink   (input valid, status, read_value, stored_count, output ready);
endinterface

// ===== src/chm_cfg_if.sv =====
// chm_cfg_if: configuration write channel for bucket_log2
// no dependencies
interface chm_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/chained_hash_map_engine.sv =====
// Chained hash map engine: set/get/delete on 64-bit keys with 64-bit values.
// A request is accepted in the idle state, passes the split hash (mix and hash
// states), the head read and a chain check, then for each chain entry visited a
// check, an entry memory read and a key compare, then the update and the
// presentation of the word. The bucket head memory is a single-port synchronous
// RAM; the entry memories are synchronous RAMs with a separate write address.
// After reset a clearing pass writes every bucket head to null, during which no
// request is accepted.
// One request is worked at a time; the response register lets the next request
// enter while a word waits, and that request stalls at its end until the
// waiting word is taken.
module chained_hash_map_engine import chm_pkg::*; #(
  parameter int MAX_BUCKET_BITS = 10,
  parameter int POOL_ENTRIES    = 1024
) (
  input logic     clk,
  input logic     rst,
  chm_cfg_if.sink cfg,
  chm_req_if.sink req,
  chm_rsp_if.source rsp
);
  localparam int BUCKETS = 1 << MAX_BUCKET_BITS;
  localparam int IW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int BW = MAX_BUCKET_BITS;
  localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_MIX   = 11'b00000000100,
    S_HASH  = 11'b00000001000,
    S_HEAD  = 11'b00000010000,
    S_CHK   = 11'b00000100000,
    S_RDE   = 11'b00001000000,
    S_CMP   = 11'b00010000000,
    S_UPD   = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_WAIT  = 11'b10000000000
  } state_t;

  state_t state;

  // memories
  logic [IW-1:0]    heads [BUCKETS];
  logic [KEY_W-1:0] ekeys [POOL_ENTRIES];
  logic [VAL_W-1:0] evals [POOL_ENTRIES];
  logic [IW-1:0]    elinks [POOL_ENTRIES];

  logic [BW-1:0]    h_addr;
  logic             h_we;
  logic [IW-1:0]    h_wdata, h_rdata;
  logic [AW-1:0]    e_addr;
  logic [KEY_W-1:0] k_rdata;
  logic [VAL_W-1:0] v_rdata;
  logic [IW-1:0]    l_rdata;

  always_ff @(posedge clk) begin
    if (h_we) heads[h_addr] <= h_wdata;
    h_rdata <= heads[h_addr];
  end
  always_ff @(posedge clk) begin
    k_rdata <= ekeys[e_addr];
    v_rdata <= evals[e_addr];
    l_rdata <= elinks[e_addr];
  end

  logic [3:0]       bucket_log2;
  logic [1:0]       kind;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic [BW-1:0]    bucket;
  logic [BW-1:0]    clr_idx;
  logic [IW-1:0]    cur, prev, head_val, free_head, fresh_next;
  logic [IW-1:0]    entry_count;
  logic [31:0]      fold;
  logic [4:0]       bits_eff;
  logic [BW-1:0]    bmask;
  logic             found;
  logic [1:0]       st;
  logic [VAL_W-1:0] rd;
  logic             rsp_full;

  chm_hash u_hash (.clk(clk), .key(key), .fold(fold));

  always_comb begin
    bits_eff = {1'b0, bucket_log2};
    if (bits_eff < 5'd1) bits_eff = 5'd1;
    if (32'(bits_eff) > MAX_BUCKET_BITS) bits_eff = 5'(MAX_BUCKET_BITS);
    bmask = BW'((32'd1 << bits_eff) - 32'd1);
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_full;

  // entry write port (key, value, link shared address)
  logic          ew_key, ew_val, ew_link;
  logic [AW-1:0] ew_addr;
  logic [IW-1:0] ew_link_d;
  always_ff @(posedge clk) begin
    if (ew_key)  ekeys[ew_addr]  <= key;
    if (ew_val)  evals[ew_addr]  <= value;
    if (ew_link) elinks[ew_addr] <= ew_link_d;
  end

  logic          is_hit;
  assign is_hit = (k_rdata == key);

  always_comb begin
    h_addr  = bucket;
    h_we    = 1'b0;
    h_wdata = NIL;
    e_addr  = AW'(cur);
    ew_key  = 1'b0;
    ew_val  = 1'b0;
    ew_link = 1'b0;
    ew_addr = AW'(cur);
    ew_link_d = NIL;
    case (state)
      S_CLEAR: begin
        h_addr = clr_idx;
        h_we   = 1'b1;
      end
      S_HASH: h_addr = BW'(fold) & bmask;
      S_UPD: begin
        case (kind)
          KIND_SET: begin
            // fetch the old link of the free list head for the pop
            if (!found) e_addr = AW'(free_head);
            if (found) begin
              ew_val = 1'b1;
            end else if (free_head < NIL || fresh_next < NIL) begin
              ew_addr = (free_head < NIL) ? AW'(free_head) : AW'(fresh_next);
              ew_key = 1'b1;
              ew_val = 1'b1;
              ew_link = 1'b1;
              ew_link_d = head_val;
              h_we = 1'b1;
              h_wdata = (free_head < NIL) ? free_head : fresh_next;
            end
          end
          KIND_DEL: begin
            if (found) begin
              ew_link = 1'b1;
              ew_link_d = free_head;
              if (prev == NIL) begin
                h_we = 1'b1;
                h_wdata = l_rdata;
              end
            end
          end
          default: ;
        endcase
      end
      S_FIN: begin
        // second write for delete with a predecessor
        if (kind == KIND_DEL && found && prev != NIL) begin
          ew_link = 1'b1;
          ew_addr = AW'(prev);
          ew_link_d = head_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      bucket_log2 <= 4'd8;
      free_head <= NIL;
      fresh_next <= '0;
      entry_count <= '0;
      rsp_full <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cfg.valid) bucket_log2 <= cfg.data;
      if (rsp_full && rsp.ready && state != S_FIN && state != S_WAIT) rsp_full <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == BUCKETS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            kind  <= req.kind;
            key   <= req.key;
            value <= req.value;
            state <= S_MIX;
          end
        end
        // first half of the hash settles into its pipeline register
        S_MIX: state <= S_HASH;
        S_HASH: begin
          bucket <= BW'(fold) & bmask;
          prev  <= NIL;
          found <= 1'b0;
          state <= S_HEAD;
        end
        S_HEAD: begin
          head_val <= (h_rdata > NIL) ? NIL : h_rdata;
          cur <= (h_rdata > NIL) ? NIL : h_rdata;
          state <= S_CHK;
        end
        S_CHK: state <= (cur < NIL) ? S_RDE : S_UPD;
        S_RDE: state <= S_CMP;
        S_CMP: begin
          if (is_hit) begin
            found <= 1'b1;
            rd <= v_rdata;
            state <= S_UPD;
          end else begin
            prev <= cur;
            cur <= (l_rdata < NIL) ? l_rdata : NIL;
            state <= S_CHK;
          end
        end
        S_UPD: begin
          st <= ST_NOTFOUND;
          case (kind)
            KIND_SET: begin
              if (found) st <= ST_OK;
              else if (free_head < NIL) begin
                entry_count <= entry_count + 1'b1;
                st <= ST_OK;
              end else if (fresh_next < NIL) begin
                fresh_next <= fresh_next + 1'b1;
                entry_count <= entry_count + 1'b1;
                st <= ST_OK;
              end else st <= ST_FULL;
            end
            KIND_GET: if (found) st <= ST_OK;
            KIND_DEL: begin
              if (found) begin
                head_val <= (l_rdata < NIL) ? l_rdata : NIL;
                free_head <= cur;
                if (entry_count != '0) entry_count <= entry_count - 1'b1;
                st <= ST_OK;
              end
            end
            default: ;
          endcase
          state <= S_FIN;
        end
        S_FIN: begin
          // pop the free list with the link read during the update
          if (kind == KIND_SET && !found && free_head < NIL) begin
            free_head <= (l_rdata < NIL) ? l_rdata : NIL;
          end
          if (!rsp_full || rsp.ready) begin
            state <= S_IDLE;
            rsp_full <= 1'b1;
            rsp.status <= st;
            rsp.read_value <= (kind == KIND_GET && found) ? rd : '0;
            rsp.stored_count <= CNT_W'(entry_count);
          end else begin
            state <= S_WAIT;
          end
        end
        // previous word still waiting in the response register
        S_WAIT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
            rsp.status <= st;
            rsp.read_value <= (kind == KIND_GET && found) ? rd : '0;
            rsp.stored_count <= CNT_W'(entry_count);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/chm_hash.sv =====
// chm_hash: two-stage pipelined 64-bit integer mix, folded to 32 bits
// depends on chm_pkg
module chm_hash import chm_pkg::*; (
  input  logic             clk,
  input  logic [KEY_W-1:0] key,
  output logic [31:0]      fold
);
  logic [63:0] a, b, c, mid, d, e, f, g;

  always_comb begin
    a = (~key) + (key << 21);
    b = a ^ (a >> 24);
    c = b + (b << 3) + (b << 8);
  end

  always_ff @(posedge clk) begin
    mid <= c;
  end

  always_comb begin
    d = mid ^ (mid >> 14);
    e = d + (d << 2) + (d << 4);
    f = e ^ (e >> 28);
    g = f + (f << 31);
    fold = g[31:0] ^ g[63:32];
  end
endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for chained_hash_map_engine, set/get/delete with a
// shadow hash map, random idling on both channels and bucket size changes
// depends on chm_pkg, chm_cfg_if, chm_req_if, chm_rsp_if and the engine
`timescale 1ns / 1ps

module tb;
  import chm_pkg::*;

  localparam int POOL = 1024;
  localparam int MAX_BITS = 10;
  localparam logic [10:0] NIL = 11'd1024;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] key;
    logic [63:0] value;
  } map_req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] read_value;
    logic [10:0] stored_count;
  } map_rsp_t;

  logic clk;
  logic rst;

  chm_cfg_if cfg ();
  chm_req_if req ();
  chm_rsp_if rsp ();

  chained_hash_map_engine #(
    .MAX_BUCKET_BITS(MAX_BITS),
    .POOL_ENTRIES(POOL)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .rsp(rsp)
  );

  // shadow copy of the map
  logic [10:0] shadow_heads [1 << MAX_BITS];
  logic [63:0] shadow_keys [POOL];
  logic [63:0] shadow_vals [POOL];
  logic [10:0] shadow_links [POOL];
  logic [10:0] shadow_free;
  logic [10:0] shadow_fresh;
  logic [10:0] shadow_count;
  logic [3:0]  shadow_log2;

  map_req_t pending_reqs [$];
  map_rsp_t expected_rsps [$];
  logic [63:0] key_pool [48];

  int gap_pct;
  int stall_pct;
  int fails;
  int cycles;
  bit req_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] wang_mix(logic [63:0] n);
    n = ~n + (n << 21);
    n = n ^ (n >> 24);
    n = n + (n << 3) + (n << 8);
    n = n ^ (n >> 14);
    n = n + (n << 2) + (n << 4);
    n = n ^ (n >> 28);
    n = n + (n << 31);
    return n;
  endfunction

  function automatic logic [9:0] bucket_index(logic [63:0] key, logic [3:0] log2);
    logic [63:0] h;
    int bits;
    h = wang_mix(key);
    h = h ^ (h >> 32);
    bits = log2;
    if (bits < 1) bits = 1;
    if (bits > MAX_BITS) bits = MAX_BITS;
    return h[9:0] & 10'((1 << bits) - 1);
  endfunction

  task automatic apply_request(input map_req_t r, output map_rsp_t x);
    logic [9:0] b;
    logic [10:0] e, prev, hit, n;
    int steps;
    x = '{status: ST_NOTFOUND, read_value: 64'd0, stored_count: 11'd0};
    b = bucket_index(r.key, shadow_log2);
    prev = NIL;
    hit = NIL;
    e = shadow_heads[b];
    steps = 0;
    while (e != NIL && hit == NIL && steps < POOL) begin
      if (shadow_keys[e] == r.key) hit = e;
      else begin
        prev = e;
        e = shadow_links[e];
        steps++;
      end
    end
    case (r.kind)
      KIND_SET: begin
        if (hit != NIL) begin
          shadow_vals[hit] = r.value;
          x.status = ST_OK;
        end else begin
          n = NIL;
          if (shadow_free != NIL) begin
            n = shadow_free;
            shadow_free = shadow_links[n];
          end else if (shadow_fresh != NIL) begin
            n = shadow_fresh;
            shadow_fresh++;
          end
          if (n != NIL) begin
            shadow_keys[n] = r.key;
            shadow_vals[n] = r.value;
            shadow_links[n] = shadow_heads[b];
            shadow_heads[b] = n;
            shadow_count++;
            x.status = ST_OK;
          end else begin
            x.status = ST_FULL;
          end
        end
      end
      KIND_GET: begin
        if (hit != NIL) begin
          x.read_value = shadow_vals[hit];
          x.status = ST_OK;
        end
      end
      KIND_DEL: begin
        if (hit != NIL) begin
          if (prev != NIL) shadow_links[prev] = shadow_links[hit];
          else shadow_heads[b] = shadow_links[hit];
          shadow_links[hit] = shadow_free;
          shadow_free = hit;
          if (shadow_count > 0) shadow_count--;
          x.status = ST_OK;
        end
      end
      default: ;
    endcase
    x.stored_count = shadow_count;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
        req.valid <= 1'b1;
        req.kind <= pending_reqs[0].kind;
        req.key <= pending_reqs[0].key;
        req.value <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // accepted requests feed the shadow map, accepted words are checked
  always @(posedge clk) begin
    map_req_t r;
    map_rsp_t x;
    map_rsp_t want;
    req_taken = 1'b0;
    if (!rst && req.valid && req.ready) begin
      req_taken = 1'b1;
      r = '{kind: kind_t'(req.kind), key: req.key, value: req.value};
      apply_request(r, x);
      expected_rsps.push_back(x);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected word: status %0d count %0d", rsp.status, rsp.stored_count);
        fails++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          fails++;
        end
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
          fails++;
        end
        if (rsp.stored_count !== want.stored_count) begin
          $error("stored_count: expected %0d, got %0d", want.stored_count,
                 rsp.stored_count);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic push_req(kind_t k, logic [63:0] key, logic [63:0] value);
    map_req_t r;
    r = '{kind: k, key: key, value: value};
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bucket_log2(logic [3:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!(cfg.valid && cfg.ready)) @(posedge clk);
    shadow_log2 = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count);
    int r;
    kind_t k;
    logic [63:0] key, value;
    for (int i = 0; i < 6; i++) key_pool[2 + $urandom_range(45)] = rand64();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) k = KIND_SET;
      else if (r < 75) k = KIND_GET;
      else if (r < 97) k = KIND_DEL;
      else k = KIND_BAD;
      key = ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(47)];
      r = $urandom_range(19);
      value = (r == 0) ? 64'd0 : (r == 1) ? '1 : rand64();
      push_req(k, key, value);
    end
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin gap_pct = 0; stall_pct = 0; end
      1: begin gap_pct = 83; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 83; end
      default: begin gap_pct = 34; stall_pct = 34; end
    endcase
  endtask

  initial begin
    logic [3:0] sizes [6];
    logic [63:0] fill_keys [$];
    int need;
    sizes = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd5, 4'd8};
    fails = 0;
    cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    req_taken = 1'b0;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.data = 4'd0;
    req.valid = 1'b0;
    req.kind = 2'd0;
    req.key = 64'd0;
    req.value = 64'd0;
    rsp.ready = 1'b0;
    foreach (shadow_heads[i]) shadow_heads[i] = NIL;
    foreach (shadow_links[i]) shadow_links[i] = NIL;
    shadow_free = NIL;
    shadow_fresh = 11'd0;
    shadow_count = 11'd0;
    shadow_log2 = 4'd8;
    foreach (key_pool[i]) key_pool[i] = rand64();
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every kind, missing keys, overwrite
    push_req(KIND_GET, 64'd0, 64'd0);
    push_req(KIND_SET, 64'd0, '1);
    push_req(KIND_SET, '1, 64'd0);
    push_req(KIND_GET, 64'd0, 64'd5);
    push_req(KIND_GET, '1, 64'd0);
    push_req(KIND_SET, 64'd0, 64'h0123_4567_89ab_cdef);
    push_req(KIND_GET, 64'd0, 64'd0);
    push_req(KIND_BAD, 64'd0, '1);
    push_req(KIND_DEL, 64'd0, 64'd0);
    push_req(KIND_GET, 64'd0, 64'd0);
    push_req(KIND_DEL, 64'd0, 64'd0);
    push_req(KIND_SET, 64'h8000_0000_0000_0000, '1);
    push_req(KIND_SET, 64'd1, 64'd1);
    push_req(KIND_DEL, '1, 64'd0);
    push_req(KIND_SET, 64'd2, 64'd2);
    push_req(KIND_GET, 64'h8000_0000_0000_0000, 64'd0);
    wait_idle();

    // bucket size changes while keys are held, out of range values included
    for (int p = 0; p < 6; p++) begin
      write_bucket_log2(sizes[p]);
      set_idling(p);
      random_phase(110);
      wait_idle();
    end

    // fill the pool, then run into full, overwrite, free and reuse
    write_bucket_log2(4'd10);
    set_idling(3);
    need = POOL - shadow_count + 12;
    for (int i = 0; i < need; i++) begin
      fill_keys.push_back(rand64());
      push_req(KIND_SET, fill_keys[i], rand64());
      if (i == need / 3) gap_pct = 0;
    end
    for (int i = 0; i < 6; i++) begin
      push_req(KIND_SET, fill_keys[$urandom_range(need - 20)], rand64());
      push_req(KIND_GET, fill_keys[$urandom_range(need - 20)], 64'd0);
    end
    for (int i = 0; i < 10; i++) push_req(KIND_DEL, fill_keys[i], 64'd0);
    for (int i = 0; i < 14; i++) push_req(KIND_SET, rand64(), rand64());
    stall_pct = 83;
    random_phase(60);
    wait_idle();
    repeat (20) @(posedge clk);

    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/chm_pkg.sv
src/chm_req_if.sv
src/chm_rsp_if.sv
src/chm_cfg_if.sv
src/chm_hash.sv
src/chained_hash_map_engine.sv
sim/tb.sv
